/* design/ppt_pkg.sv */
// Shared types, constants and helper functions of the periodic priority task picker.
package ppt_pkg;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int TIME_BITS_DEF  = 32;
  localparam int TIME_BITS_MAX  = 48;

  localparam int NOW_BITS       = 32;
  localparam int INDEX_BITS     = 3;
  localparam int RUN_BITS       = 32;
  localparam int PRI_BITS       = 4;
  localparam int PERIOD_BITS    = 16;
  localparam int COUNT_BITS     = 4;
  localparam int MASK_BITS      = 8;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TASK_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_READY_MASK   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRIORITY     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD_LOW   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD_HIGH  = 3'd4;

  localparam logic [MASK_BITS-1:0] READY_MASK_RESET = 8'hFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture tick time, restart scan
    logic step;    // examine one slot
    logic commit;  // update chosen slot and load output register
  } ppt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ppt_stat_t;

  function automatic logic [PRI_BITS-1:0] slot_priority(
    input logic [31:0] words,
    input logic [INDEX_BITS-1:0] slot
  );
    return words[{slot, 2'b00} +: PRI_BITS];
  endfunction

  function automatic logic [PERIOD_BITS-1:0] slot_period(
    input logic [63:0] low_words,
    input logic [63:0] high_words,
    input logic [INDEX_BITS-1:0] slot
  );
    logic [127:0] all_words;
    all_words = {high_words, low_words};
    return all_words[{slot, 4'b0000} +: PERIOD_BITS];
  endfunction

endpackage

/* design/ppt_if.sv */
// Channel interfaces: tick input, pick result and configuration write.
interface ppt_tick_if import ppt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [NOW_BITS-1:0] now_time;

  modport source (output valid, output now_time, input ready);
  modport sink   (input valid, input now_time, output ready);
endinterface

interface ppt_pick_if import ppt_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  granted;
  logic [INDEX_BITS-1:0] task_index;
  logic [RUN_BITS-1:0]   run_number;

  modport source (output valid, output granted, output task_index, output run_number,
                  input ready);
  modport sink   (input valid, input granted, input task_index, input run_number,
                  output ready);
endinterface

interface ppt_cfg_if import ppt_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/periodic_priority_task_picker_top.sv */
// Top level of the periodic priority task picker: controller, datapath and checks.
//
//   channel  dir  payload                           transfer when
//   tick     in   now_time                          tick.valid && tick.ready
//   pick     out  granted, task_index, run_number   pick.valid && pick.ready
//   cfg      in   index, data                       cfg.valid (ready held high)
//
// From a tick transfer to the next tick ready, the controller scans the slots in use
// one at a time on the shared compare unit, closes the scan and then commits. Reset
// clears next-due times, run counts and configuration, but sets the ready mask to all
// ones. A stalled pick output holds the commit; a new tick
// is taken while the last result waits in the output register.
module periodic_priority_task_picker_top import ppt_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  ppt_tick_if.sink   tick,
  ppt_pick_if.source pick,
  ppt_cfg_if.sink    cfg
);

  ppt_cmd_t  cmd;
  ppt_stat_t stat;
  logic      tick_ready;

  assign tick.ready = tick_ready;

  ppt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ppt_datapath #(
    .TASK_SLOTS (TASK_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .now_time (tick.now_time),
    .cmd      (cmd),
    .stat     (stat),
    .cfg      (cfg),
    .pick     (pick)
  );

`ifndef NO_ASSERTIONS
  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("commit while output register is occupied");

  a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready) |=> !tick.ready)
    else $error("tick taken while a scan is in progress");

  a_grant_counts_run: assert property (@(posedge clk) disable iff (rst)
    (pick.valid && pick.granted) |-> (pick.run_number != '0))
    else $error("grant reported with zero run number");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (pick.valid && !pick.granted) |-> (pick.task_index == '0 && pick.run_number == '0))
    else $error("no grant but result fields not zero");
`endif

endmodule

/* design/ppt_ctrl.sv */
// Controller state machine: accept a tick, sequence the slot scan, commit the pick.
module ppt_ctrl import ppt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      tick_valid,
  output logic      tick_ready,
  input  ppt_stat_t stat,
  output ppt_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    tick_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        tick_ready = 1'b1;
        if (tick_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/ppt_datapath.sv */
// Datapath: configuration registers, per-slot state, scan registers and output register.
module ppt_datapath import ppt_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [NOW_BITS-1:0] now_time,
  input  ppt_cmd_t            cmd,
  output ppt_stat_t           stat,
  ppt_cfg_if.sink             cfg,
  ppt_pick_if.source          pick
);

  localparam int SLOT_BITS = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_BITS  = $clog2(TASK_SLOTS + 1);

  // configuration
  logic [COUNT_BITS-1:0] task_count;
  logic [MASK_BITS-1:0]  ready_mask;
  logic [31:0]           priority_words;
  logic [63:0]           period_words_low;
  logic [63:0]           period_words_high;

  // per-slot state
  logic [TIME_BITS-1:0] next_due_time [TASK_SLOTS];
  logic [RUN_BITS-1:0]  run_total     [TASK_SLOTS];

  // scan registers
  logic [CNT_BITS-1:0]    cnt;
  logic [TIME_BITS-1:0]   now_reg;
  logic                   found;
  logic [SLOT_BITS-1:0]   best_idx;
  logic [PRI_BITS-1:0]    best_pri;
  logic [RUN_BITS-1:0]    best_run;
  logic [PERIOD_BITS-1:0] best_period;

  // output register
  logic                  out_valid;
  logic                  out_granted;
  logic [INDEX_BITS-1:0] out_index;
  logic [RUN_BITS-1:0]   out_run;

  logic [TIME_BITS_MAX-1:0] now_ext;
  logic [CNT_BITS-1:0]      limit;
  logic [SLOT_BITS-1:0]     idx;
  logic [INDEX_BITS-1:0]    slot;
  logic [PRI_BITS-1:0]      pri;
  logic                     hit;
  logic                     better;
  logic [TIME_BITS:0]       due_sum;
  logic [TIME_BITS-1:0]     due_new;
  logic [RUN_BITS-1:0]      run_inc;

  assign now_ext = {{(TIME_BITS_MAX-NOW_BITS){1'b0}}, now_time};

  assign limit = (task_count > COUNT_BITS'(TASK_SLOTS)) ? CNT_BITS'(TASK_SLOTS)
                                                         : CNT_BITS'(task_count);
  assign idx   = cnt[SLOT_BITS-1:0];
  assign slot  = INDEX_BITS'(idx);
  assign pri   = slot_priority(priority_words, slot);

  assign hit    = (cnt < limit) && ready_mask[slot] && (now_reg >= next_due_time[idx]);
  assign better = hit && (!found || (pri > best_pri));

  // saturate next-due time at all ones
  assign due_sum = {1'b0, now_reg} + (TIME_BITS+1)'(best_period);
  assign due_new = due_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : due_sum[TIME_BITS-1:0];
  assign run_inc = (best_run == {RUN_BITS{1'b1}}) ? best_run : best_run + RUN_BITS'(1);

  assign stat.scan_done = (cnt >= limit);
  assign stat.out_free  = !out_valid || pick.ready;

  assign cfg.ready       = 1'b1;
  assign pick.valid      = out_valid;
  assign pick.granted    = out_granted;
  assign pick.task_index = out_index;
  assign pick.run_number = out_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count        <= '0;
      ready_mask        <= READY_MASK_RESET;
      priority_words    <= '0;
      period_words_low  <= '0;
      period_words_high <= '0;
      out_valid         <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        next_due_time[i] <= '0;
        run_total[i]     <= '0;
      end
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_TASK_COUNT:  task_count        <= cfg.data[COUNT_BITS-1:0];
          REG_READY_MASK:  ready_mask        <= cfg.data[MASK_BITS-1:0];
          REG_PRIORITY:    priority_words    <= cfg.data[31:0];
          REG_PERIOD_LOW:  period_words_low  <= cfg.data;
          REG_PERIOD_HIGH: period_words_high <= cfg.data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (found) begin
          next_due_time[best_idx] <= due_new;
          run_total[best_idx]     <= run_inc;
        end
      end else if (pick.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt     <= '0;
      now_reg <= now_ext[TIME_BITS-1:0];
      found   <= 1'b0;
    end else if (cmd.step) begin
      cnt <= cnt + CNT_BITS'(1);
      if (better) begin
        found       <= 1'b1;
        best_idx    <= idx;
        best_pri    <= pri;
        best_run    <= run_total[idx];
        best_period <= slot_period(period_words_low, period_words_high, slot);
      end
    end
    if (cmd.commit) begin
      out_granted <= found;
      out_index   <= found ? INDEX_BITS'(best_idx) : '0;
      out_run     <= found ? run_inc : '0;
    end
  end

endmodule

/* tb/sv/tb.sv */
// Testbench for the periodic priority task picker: directed and random ticks checked against a predictor.
module tb import ppt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS         = 8;
  localparam int LIMIT_CYCLES  = 300000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic                  granted;
    logic [INDEX_BITS-1:0] task_index;
    logic [RUN_BITS-1:0]   run_number;
  } pick_result_t;

  logic clk;
  logic rst;

  ppt_tick_if tick_ch ();
  ppt_pick_if pick_ch ();
  ppt_cfg_if  cfg_ch ();

  periodic_priority_task_picker_top dut (
    .clk  (clk),
    .rst  (rst),
    .tick (tick_ch),
    .pick (pick_ch),
    .cfg  (cfg_ch)
  );

  // Scheduler copy: configuration and per-slot state
  logic [COUNT_BITS-1:0]    cfg_count;
  logic [MASK_BITS-1:0]     cfg_ready;
  logic [31:0]              cfg_prio;
  logic [63:0]              cfg_period_lo;
  logic [63:0]              cfg_period_hi;
  logic [NOW_BITS-1:0]      due_at [SLOTS];
  logic [RUN_BITS-1:0]      run_count [SLOTS];

  pick_result_t        pending_picks [$];
  int                  errors;
  int                  tick_idle_pct;
  int                  pick_idle_pct;
  int                  hold_left;
  int unsigned         cycle_count;
  logic [NOW_BITS-1:0] now_cur;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("periodic_priority_task_picker_top: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_left runs down
  initial begin
    pick_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pick_ch.ready = 1'b0;
        hold_left--;
      end else begin
        pick_ch.ready = ($urandom_range(99) >= pick_idle_pct);
      end
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t %s: got %0h expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_picks
    pick_result_t got;
    pick_result_t want;
    if (!rst && pick_ch.valid && pick_ch.ready) begin
      got = {pick_ch.granted, pick_ch.task_index, pick_ch.run_number};
      if (pending_picks.size() == 0) begin
        report_mismatch("pick with nothing pending", 64'(got), 64'd0);
      end else begin
        want = pending_picks.pop_front();
        if (got.granted !== want.granted)
          report_mismatch("granted", 64'(got.granted), 64'(want.granted));
        if (got.task_index !== want.task_index)
          report_mismatch("task_index", 64'(got.task_index), 64'(want.task_index));
        if (got.run_number !== want.run_number)
          report_mismatch("run_number", 64'(got.run_number), 64'(want.run_number));
      end
    end
  end

  function automatic void reset_scheduler();
    cfg_count     = '0;
    cfg_ready     = READY_MASK_RESET;
    cfg_prio      = '0;
    cfg_period_lo = '0;
    cfg_period_hi = '0;
    for (int i = 0; i < SLOTS; i++) begin
      due_at[i]    = '0;
      run_count[i] = '0;
    end
  endfunction

  // Pick the highest-priority due slot (lowest index on a tie) and advance it
  function automatic pick_result_t pick_due_task(logic [NOW_BITS-1:0] now);
    pick_result_t        res;
    int                  limit;
    bit                  found;
    int                  best;
    logic [PRI_BITS-1:0] best_pri;
    logic [PRI_BITS-1:0] pri;
    logic [127:0]        periods;
    logic [NOW_BITS:0]   sum;
    res      = '0;
    found    = 1'b0;
    best     = 0;
    best_pri = '0;
    limit    = (cfg_count > SLOTS) ? SLOTS : int'(cfg_count);
    for (int i = 0; i < limit; i++) begin
      pri = cfg_prio[PRI_BITS*i +: PRI_BITS];
      if (cfg_ready[i] && now >= due_at[i] && (!found || pri > best_pri)) begin
        found    = 1'b1;
        best     = i;
        best_pri = pri;
      end
    end
    if (found) begin
      periods = {cfg_period_hi, cfg_period_lo};
      sum = {1'b0, now} + (NOW_BITS+1)'(periods[PERIOD_BITS*best +: PERIOD_BITS]);
      due_at[best] = sum[NOW_BITS] ? '1 : sum[NOW_BITS-1:0];
      if (run_count[best] != '1)
        run_count[best] = run_count[best] + 1'b1;
      res.granted    = 1'b1;
      res.task_index = best[INDEX_BITS-1:0];
      res.run_number = run_count[best];
    end
    return res;
  endfunction

  // Leaves valid high after the transfer; drain_picks lowers it, as does the next call when it idles
  task automatic send_tick(logic [NOW_BITS-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < tick_idle_pct) begin
      tick_ch.valid = 1'b0;
      @(negedge clk);
    end
    tick_ch.valid    = 1'b1;
    tick_ch.now_time = now;
    do @(posedge clk); while (!tick_ch.ready);
    pending_picks.push_back(pick_due_task(now));
  endtask

  task automatic drain_picks();
    @(negedge clk);
    tick_ch.valid = 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_TASK_COUNT:  cfg_count     = value[COUNT_BITS-1:0];
      REG_READY_MASK:  cfg_ready     = value[MASK_BITS-1:0];
      REG_PRIORITY:    cfg_prio      = value[31:0];
      REG_PERIOD_LOW:  cfg_period_lo = value;
      REG_PERIOD_HIGH: cfg_period_hi = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic write_random_config();
    logic [63:0] data;
    logic [63:0] lo;
    logic [63:0] hi;
    data = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       data[COUNT_BITS-1:0] = '0;
      1:       data[COUNT_BITS-1:0] = COUNT_BITS'($urandom_range(9, 15));
      default: data[COUNT_BITS-1:0] = COUNT_BITS'($urandom_range(1, SLOTS));
    endcase
    write_reg(REG_TASK_COUNT, data);
    data = {$urandom, $urandom};
    if ($urandom_range(7) != 0)
      data[MASK_BITS-1:0] = MASK_BITS'($urandom | $urandom);
    write_reg(REG_READY_MASK, data);
    write_reg(REG_PRIORITY, {$urandom, $urandom});
    for (int k = 0; k < 4; k++) begin
      lo[PERIOD_BITS*k +: PERIOD_BITS] = ($urandom_range(7) == 0) ?
          PERIOD_BITS'($urandom) : PERIOD_BITS'($urandom_range(0, 12));
      hi[PERIOD_BITS*k +: PERIOD_BITS] = ($urandom_range(7) == 0) ?
          PERIOD_BITS'($urandom) : PERIOD_BITS'($urandom_range(0, 12));
    end
    write_reg(REG_PERIOD_LOW, lo);
    write_reg(REG_PERIOD_HIGH, hi);
    if ($urandom_range(3) == 0)
      write_reg(CFG_INDEX_BITS'($urandom_range(5, 7)), {$urandom, $urandom});
  endtask

  // Mostly a clock that creeps forward, with a few arbitrary times mixed in
  task automatic random_ticks(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 3) begin
        send_tick($urandom);
      end else begin
        now_cur = now_cur + NOW_BITS'($urandom_range(0, 4));
        send_tick(now_cur);
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_tick('0);
    send_tick('1);
    drain_picks();
  endtask

  task automatic test_directed();
    write_reg(REG_TASK_COUNT, 64'd3);
    write_reg(REG_PRIORITY, 64'h0000_0552);
    write_reg(REG_PERIOD_LOW, 64'h0000_0004_0003_000A);
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd2);
    send_tick(32'd2);
    send_tick(32'd3);
    drain_picks();
    // block task one
    write_reg(REG_READY_MASK, 64'hFFFF_FFFF_FFFF_FFFD);
    send_tick(32'd10);
    send_tick(32'd10);
    drain_picks();
    // oversized count, every priority equal, all-ones and zero periods
    write_reg(REG_TASK_COUNT, 64'd15);
    write_reg(REG_READY_MASK, 64'hFF);
    write_reg(REG_PRIORITY, 64'hFFFF_FFFF);
    write_reg(REG_PERIOD_HIGH, 64'hFFFF_0000_0001_0000);
    send_tick(32'd20);
    send_tick(32'd20);
    send_tick(32'd20);
    send_tick(32'd21);
    drain_picks();
    for (int r = 5; r < 8; r++)
      write_reg(CFG_INDEX_BITS'(r), '1);
    send_tick(32'd30);
    drain_picks();
    write_reg(REG_TASK_COUNT, 64'hFFFF_FFFF_FFFF_FFF0);
    send_tick(32'd40);
    drain_picks();
    write_reg(REG_TASK_COUNT, 64'd8);
    write_reg(REG_READY_MASK, 64'h0);
    send_tick(32'd50);
    drain_picks();
    // lone task seven at priority zero, next-due saturates near the top
    write_reg(REG_READY_MASK, 64'h80);
    write_reg(REG_PRIORITY, 64'h0);
    send_tick(32'hFFFF_FFF0);
    send_tick(32'hFFFF_FFFE);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF);
    drain_picks();
  endtask

  task automatic test_random(int tick_pct, int pick_pct, logic [NOW_BITS-1:0] base);
    tick_idle_pct = tick_pct;
    pick_idle_pct = pick_pct;
    now_cur       = base;
    repeat (4) begin
      drain_picks();
      write_random_config();
      random_ticks(50);
    end
    drain_picks();
  endtask

  task automatic test_backpressure();
    tick_idle_pct = 0;
    pick_idle_pct = 0;
    write_reg(REG_TASK_COUNT, 64'd8);
    write_reg(REG_READY_MASK, 64'hFF);
    write_reg(REG_PRIORITY, {$urandom, $urandom});
    write_reg(REG_PERIOD_LOW, 64'h0);
    write_reg(REG_PERIOD_HIGH, 64'h0);
    send_tick(now_cur);
    // hold the pick side while ticks keep coming
    hold_left = HOLD_CYCLES;
    random_ticks(30);
    drain_picks();
  endtask

  initial begin
    tick_ch.valid    = 1'b0;
    tick_ch.now_time = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    errors           = 0;
    hold_left        = 0;
    cycle_count      = 0;
    now_cur          = '0;
    tick_idle_pct    = 25;
    pick_idle_pct    = 47;
    reset_scheduler();
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_directed();
    test_random(25, 47, 32'h0000_0100);
    test_random(47, 25, NOW_BITS'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)));
    test_random(0, 0, 32'hFFFF_FE80);
    test_backpressure();

    if (errors == 0) begin
      $display("periodic_priority_task_picker_top: match");
    end else begin
      $display("periodic_priority_task_picker_top: mismatch");
    end
    $finish;
  end

endmodule
